/* rtl/core/evad_pkg.sv */
// Shared types, constants and helpers for the energy voice activity detector.
// Depends on nothing; every other file of the block but evad_fifo uses it by scoped names.
`default_nettype none

package evad_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int LEVEL_W       = 16;
    localparam int THR_W         = 16;
    localparam int RUN_W         = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_CHUNK_DEF = 1024;
    localparam int QUEUE_DEPTH   = 2;

    localparam longint MAG_MAX = longint'(1) << (SAMPLE_BITS - 1);

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] REG_THR_IDLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THR_SPEAKER    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_IDLE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_SPEAKER  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_IDLE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_SPEAKER   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_MODE      = 3'd6;

    localparam logic [THR_W-1:0] RST_THR_IDLE      = 16'd600;
    localparam logic [THR_W-1:0] RST_THR_SPEAKER   = 16'd1800;
    localparam logic [RUN_W-1:0] RST_START_IDLE    = 8'd4;
    localparam logic [RUN_W-1:0] RST_START_SPEAKER = 8'd8;
    localparam logic [RUN_W-1:0] RST_STOP_IDLE     = 8'd12;
    localparam logic [RUN_W-1:0] RST_STOP_SPEAKER  = 8'd14;
    localparam logic             RST_PEAK_MODE     = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          chunk_last;
        logic                          speaker_on;
        logic                          codec_output_on;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak_level;
        logic               chunk_active;
        logic               speaking;
        logic               speech_start;
        logic               speech_end;
    } t_result;

    typedef struct packed {
        logic [THR_W-1:0] threshold_idle;
        logic [THR_W-1:0] threshold_speaker;
        logic [RUN_W-1:0] start_chunks_idle;
        logic [RUN_W-1:0] start_chunks_speaker;
        logic [RUN_W-1:0] stop_chunks_idle;
        logic [RUN_W-1:0] stop_chunks_speaker;
        logic             peak_mode;
    } t_cfg;

    typedef struct packed {
        logic                   is_reset;
        logic                   speaker_on;
        logic                   codec_output_on;
        logic [SAMPLE_BITS-1:0] peak;
    } t_chunk_info;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        logic [SAMPLE_BITS-1:0] u;
        u = SAMPLE_BITS'(s);
        return u[SAMPLE_BITS-1] ? (~u + SAMPLE_BITS'(1)) : u;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/energy_voice_activity_detector_core.sv */
// Energy voice activity detector with hangover. Samples enter through push
// at one per cycle while full is low; the front accumulates the chunk's
// magnitude sum and peak in that same cycle. Each chunk end or reset item
// queues a record (two entries deep) for the back, whose radix-2 divider
// divides the sum by the count bit by bit before the decision; the back takes
// a new record only once it is through with the last. full rises only when
// chunks close faster than the back drains them or results wait unpopped.
// Results wait in an output register until popped. Configuration registers
// are always ready. Depends on evad_pkg, evad_front, evad_fifo and evad_back.
`default_nettype none

module energy_voice_activity_detector_core #(
    parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire evad_pkg::t_item                     i_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output evad_pkg::t_result                        o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [evad_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [evad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SUM_W = $clog2(longint'(MAX_CHUNK) * evad_pkg::MAG_MAX + longint'(1));
    localparam int CNT_W = $clog2(MAX_CHUNK + 1);
    localparam int REC_W = SUM_W + CNT_W + $bits(evad_pkg::t_chunk_info);

    evad_pkg::t_cfg         r_cfg;
    logic                   rec_push;
    logic [SUM_W-1:0]       rec_sum;
    logic [CNT_W-1:0]       rec_cnt;
    evad_pkg::t_chunk_info  rec_info;
    logic [REC_W-1:0]       q_rdata;
    logic                   q_empty;
    logic                   q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_idle       <= evad_pkg::RST_THR_IDLE;
            r_cfg.threshold_speaker    <= evad_pkg::RST_THR_SPEAKER;
            r_cfg.start_chunks_idle    <= evad_pkg::RST_START_IDLE;
            r_cfg.start_chunks_speaker <= evad_pkg::RST_START_SPEAKER;
            r_cfg.stop_chunks_idle     <= evad_pkg::RST_STOP_IDLE;
            r_cfg.stop_chunks_speaker  <= evad_pkg::RST_STOP_SPEAKER;
            r_cfg.peak_mode            <= evad_pkg::RST_PEAK_MODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                evad_pkg::REG_THR_IDLE:      r_cfg.threshold_idle <= i_cfg_data;
                evad_pkg::REG_THR_SPEAKER:   r_cfg.threshold_speaker <= i_cfg_data;
                evad_pkg::REG_START_IDLE:
                    r_cfg.start_chunks_idle <= i_cfg_data[evad_pkg::RUN_W-1:0];
                evad_pkg::REG_START_SPEAKER:
                    r_cfg.start_chunks_speaker <= i_cfg_data[evad_pkg::RUN_W-1:0];
                evad_pkg::REG_STOP_IDLE:
                    r_cfg.stop_chunks_idle <= i_cfg_data[evad_pkg::RUN_W-1:0];
                evad_pkg::REG_STOP_SPEAKER:
                    r_cfg.stop_chunks_speaker <= i_cfg_data[evad_pkg::RUN_W-1:0];
                evad_pkg::REG_PEAK_MODE:     r_cfg.peak_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    evad_front #(
        .MAX_CHUNK (MAX_CHUNK),
        .SUM_W     (SUM_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_item     (i_item),
        .o_rec_push (rec_push),
        .o_rec_sum  (rec_sum),
        .o_rec_cnt  (rec_cnt),
        .o_rec_info (rec_info)
    );

    evad_fifo #(
        .WIDTH (REC_W),
        .DEPTH (evad_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_wdata ({rec_sum, rec_cnt, rec_info}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    evad_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_sum   (q_rdata[REC_W-1 -: SUM_W]),
        .i_q_cnt   (q_rdata[REC_W-SUM_W-1 -: CNT_W]),
        .i_q_info  (evad_pkg::t_chunk_info'(q_rdata[$bits(evad_pkg::t_chunk_info)-1:0])),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

/* rtl/core/evad_fifo.sv */
// Small register queue between the accumulating front and the deciding back.
// Generic width and depth; uses no package.
`default_nettype none

module evad_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/evad_front.sv */
// Front end: takes one item per cycle while accepted, accumulates sum and peak of
// magnitudes, and queues a chunk record at chunk end or on a reset item. Uses evad_pkg.
`default_nettype none

module evad_front #(
    parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF,
    parameter int SUM_W     = 26,
    parameter int CNT_W     = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire evad_pkg::t_item      i_item,
    output logic                      o_rec_push,
    output logic [SUM_W-1:0]          o_rec_sum,
    output logic [CNT_W-1:0]          o_rec_cnt,
    output evad_pkg::t_chunk_info     o_rec_info
);

    logic [SUM_W-1:0]                   r_sum;
    logic [CNT_W-1:0]                   r_cnt;
    logic [evad_pkg::SAMPLE_BITS-1:0]   r_peak;
    logic [SUM_W-1:0]                   n_sum;
    logic [CNT_W-1:0]                   n_cnt;
    logic [evad_pkg::SAMPLE_BITS-1:0]   n_peak;
    logic [evad_pkg::SAMPLE_BITS-1:0]   mag;
    logic                               room;

    assign mag  = evad_pkg::magnitude(i_item.sample);
    assign room = (r_cnt < CNT_W'(MAX_CHUNK));

    always_comb begin
        n_sum  = r_sum;
        n_cnt  = r_cnt;
        n_peak = r_peak;
        if (room) begin
            n_sum  = r_sum + SUM_W'(mag);
            n_cnt  = r_cnt + CNT_W'(1);
            n_peak = (mag > r_peak) ? mag : r_peak;
        end
    end

    assign o_rec_push = i_accept && (i_item.mode || i_item.chunk_last);
    assign o_rec_sum  = n_sum;
    assign o_rec_cnt  = n_cnt;
    always_comb begin
        o_rec_info.is_reset        = i_item.mode;
        o_rec_info.speaker_on      = i_item.speaker_on;
        o_rec_info.codec_output_on = i_item.codec_output_on;
        o_rec_info.peak            = n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_peak <= '0;
        end else if (i_accept) begin
            if (i_item.mode || i_item.chunk_last) begin
                r_sum  <= '0;
                r_cnt  <= '0;
                r_peak <= '0;
            end else begin
                r_sum  <= n_sum;
                r_cnt  <= n_cnt;
                r_peak <= n_peak;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/evad_back.sv */
// Back end: pops chunk records, divides sum by count one bit per cycle,
// applies thresholds and run counters, holds the result register. Uses evad_pkg.
`default_nettype none

module evad_back #(
    parameter int SUM_W = 26,
    parameter int CNT_W = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire evad_pkg::t_cfg       i_cfg,
    input  wire logic                 i_q_empty,
    input  wire logic [SUM_W-1:0]     i_q_sum,
    input  wire logic [CNT_W-1:0]     i_q_cnt,
    input  wire evad_pkg::t_chunk_info i_q_info,
    output logic                      o_q_pop,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output evad_pkg::t_result         o_result
);

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} t_state;

    t_state                    r_state;
    logic [SUM_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic [STEP_W-1:0]         r_step;
    evad_pkg::t_chunk_info     r_info;
    logic [evad_pkg::RUN_W-1:0] r_active_run;
    logic [evad_pkg::RUN_W-1:0] r_quiet_run;
    logic                      r_speech;
    logic                      r_out_valid;
    evad_pkg::t_result         r_out;

    logic [CNT_W:0]            div_trial;
    logic [CNT_W:0]            div_diff;
    logic                      div_ge;
    logic                      slot_free;
    logic                      load_out;
    logic                      spk;
    logic [evad_pkg::THR_W-1:0] thr;
    logic [evad_pkg::RUN_W-1:0] start_t;
    logic [evad_pkg::RUN_W-1:0] stop_t;
    logic [evad_pkg::LEVEL_W-1:0] avg;
    logic                      active;
    logic [evad_pkg::RUN_W-1:0] n_active_run;
    logic [evad_pkg::RUN_W-1:0] n_quiet_run;
    logic                      n_speech;
    logic                      started;
    logic                      ended;

    assign div_trial = {r_rem, r_quo[SUM_W-1]};
    assign div_diff  = div_trial - {1'b0, r_cnt};
    assign div_ge    = (div_trial >= {1'b0, r_cnt});

    assign slot_free = !r_out_valid || i_pop;
    assign load_out  = (r_state == S_DONE) && slot_free && (!r_info.is_reset || r_speech);
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        spk     = r_info.speaker_on || (i_cfg.peak_mode && r_info.codec_output_on);
        thr     = spk ? i_cfg.threshold_speaker    : i_cfg.threshold_idle;
        start_t = spk ? i_cfg.start_chunks_speaker : i_cfg.start_chunks_idle;
        stop_t  = spk ? i_cfg.stop_chunks_speaker  : i_cfg.stop_chunks_idle;
        avg     = (r_cnt == '0) ? '0 : r_quo[evad_pkg::LEVEL_W-1:0];
        active  = (avg >= thr) ||
                  (i_cfg.peak_mode &&
                   ({1'b0, r_info.peak} >= {thr, 1'b0}));

        n_active_run = r_active_run;
        n_quiet_run  = r_quiet_run;
        n_speech     = r_speech;
        started      = 1'b0;
        ended        = 1'b0;
        if (active) begin
            if (r_active_run != evad_pkg::RUN_MAX) begin
                n_active_run = r_active_run + evad_pkg::RUN_W'(1);
            end
            n_quiet_run = '0;
            if (!r_speech && (n_active_run >= start_t)) begin
                n_speech = 1'b1;
                started  = 1'b1;
            end
        end else begin
            n_active_run = '0;
            if (r_speech) begin
                if (r_quiet_run != evad_pkg::RUN_MAX) begin
                    n_quiet_run = r_quiet_run + evad_pkg::RUN_W'(1);
                end
                if (n_quiet_run >= stop_t) begin
                    n_speech    = 1'b0;
                    n_quiet_run = '0;
                    ended       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active_run <= '0;
            r_quiet_run  <= '0;
            r_speech     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_quo  <= i_q_sum;
                        r_cnt  <= i_q_cnt;
                        r_info <= i_q_info;
                        r_rem  <= '0;
                        r_step <= '0;
                        r_state <= i_q_info.is_reset ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo  <= {r_quo[SUM_W-2:0], div_ge};
                    r_rem  <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                        if (r_info.is_reset) begin
                            r_active_run <= '0;
                            r_quiet_run  <= '0;
                            r_speech     <= 1'b0;
                            if (r_speech) begin
                                r_out.level        <= '0;
                                r_out.peak_level   <= '0;
                                r_out.chunk_active <= 1'b0;
                                r_out.speaking     <= 1'b0;
                                r_out.speech_start <= 1'b0;
                                r_out.speech_end   <= 1'b1;
                            end
                        end else begin
                            r_active_run       <= n_active_run;
                            r_quiet_run        <= n_quiet_run;
                            r_speech           <= n_speech;
                            r_out.level        <= avg;
                            r_out.peak_level   <= evad_pkg::LEVEL_W'(r_info.peak);
                            r_out.chunk_active <= active;
                            r_out.speaking     <= n_speech;
                            r_out.speech_start <= started;
                            r_out.speech_end   <= ended;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/evad_checker.sv */
// Port-level checks on the detector's result side, bound to the top level.
// Depends on evad_pkg and energy_voice_activity_detector_core.
`default_nettype none

module evad_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire evad_pkg::t_result o_result
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_start_end_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.speech_start && o_result.speech_end))
        else $error("start and end reported together");

    a_start_speaking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.speech_start) |-> o_result.speaking)
        else $error("start reported while not speaking");

    a_end_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.speech_end) |-> (!o_result.speaking && !o_result.chunk_active))
        else $error("end reported while speaking or active");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or dropped");

endmodule

bind energy_voice_activity_detector_core evad_checker u_evad_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire
